FILE: rtl/core/charge_slot_mode_controller_unit_defines.svh
// Assertion macros for the charge slot mode controller.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef CHARGE_SLOT_MODE_CONTROLLER_UNIT_DEFINES_SVH
`define CHARGE_SLOT_MODE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent in this cycle implies consequent in the next
`define CSMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csmc assertion failed");
// antecedent implies consequent in the same cycle
`define CSMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csmc assertion failed");
`else
`define CSMC_ASSERT_NEXT(lbl, ante, cons)
`define CSMC_ASSERT_NOW(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/csmc_pkg.sv
// Shared types, codes and helpers for the charge slot mode controller.
// No dependencies.
`default_nettype none

package csmc_pkg;

    // slot modes, one-hot inside the block
    typedef enum logic [4:0] {
        MODE_STANDBY  = 5'b00001,
        MODE_SWAP     = 5'b00010,
        MODE_CHARGING = 5'b00100,
        MODE_FAULT    = 5'b01000,
        MODE_THEFT    = 5'b10000
    } mode_t;

    // mode encoding seen on the result word
    localparam logic [2:0] MODE_CODE_STANDBY  = 3'd0;
    localparam logic [2:0] MODE_CODE_SWAP     = 3'd1;
    localparam logic [2:0] MODE_CODE_CHARGING = 3'd2;
    localparam logic [2:0] MODE_CODE_FAULT    = 3'd3;
    localparam logic [2:0] MODE_CODE_THEFT    = 3'd4;

    // pending command bits
    localparam int CMD_LOCK_BIT   = 0;
    localparam int CMD_UNLOCK_BIT = 1;
    localparam int CMD_CHARGE_BIT = 2;
    localparam int CMD_STOP_BIT   = 3;

    localparam logic [7:0] BATT_STOP   = 8'h01;
    localparam logic [7:0] BATT_CHARGE = 8'h05;

    localparam logic [1:0] LED_NONE    = 2'd0;
    localparam logic [1:0] LED_IDLE    = 2'd1;
    localparam logic [1:0] LED_READY   = 2'd2;

    localparam logic [7:0] FULL_LEVEL_RST = 8'd100;

    typedef struct packed {
        logic       is_battery;
        logic       hw_failure;
        logic       batt_fault_a;
        logic       batt_fault_b;
        logic       charger_fault;
        logic [7:0] charge_level;
        logic       lock_req;
        logic       unlock_req;
        logic       charge_req;
        logic       stop_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] prior_mode;
        logic       locked;
        logic       wake_request;
        logic [7:0] battery_command;
        logic       charger_disable;
        logic       charging_on;
        logic [1:0] led_code;
        logic       bus_error;
        logic       unlock_waiting;
    } out_item_t;

    typedef struct packed {
        mode_t      mode;
        mode_t      prev;
        logic       lock;
        logic       wake;
        logic [7:0] batt_cmd;
        logic       chg_dis;
        logic       chg_on;
        logic [1:0] led;
        logic       bus_err;
        logic [3:0] pend;
    } slot_state_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            MODE_STANDBY:  c = MODE_CODE_STANDBY;
            MODE_SWAP:     c = MODE_CODE_SWAP;
            MODE_CHARGING: c = MODE_CODE_CHARGING;
            MODE_FAULT:    c = MODE_CODE_FAULT;
            MODE_THEFT:    c = MODE_CODE_THEFT;
            default:       c = MODE_CODE_STANDBY;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/csmc_channels.sv
// Handshake channels of the charge slot mode controller: item, result, config.
// Depends on csmc_pkg.
`default_nettype none

interface csmc_item_if;
    logic               valid;
    logic               ready;
    csmc_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface csmc_result_if;
    logic                valid;
    logic                ready;
    csmc_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface csmc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/csmc_in_reg.sv
// Input register stage: holds one accepted word until the core consumes it.
// Depends on csmc_pkg and csmc_item_if.
`default_nettype none

module csmc_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    csmc_item_if.sink       item,
    input  wire logic       adv,
    output csmc_pkg::in_item_t word,
    output logic            word_valid
);

    logic               valid_reg;
    logic               valid_next;
    csmc_pkg::in_item_t data_reg;

    // room when empty or when the held word moves on this cycle
    assign item.ready = !valid_reg || adv;

    always_comb
    begin
        valid_next = valid_reg;
        if (item.valid && item.ready)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            data_reg <= item.data;
        end
    end

    assign word       = data_reg;
    assign word_valid = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/csmc_core.sv
// Slot state registers and the per-tick mode update.
// Depends on csmc_pkg.
`default_nettype none

module csmc_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire csmc_pkg::in_item_t  word,
    input  wire logic [7:0]          full_level,
    output csmc_pkg::out_item_t      result_next,
    output csmc_pkg::slot_state_t    state
);

    csmc_pkg::slot_state_t st_reg;
    csmc_pkg::slot_state_t st_next;

    logic bfault;

    assign bfault = word.batt_fault_a | word.batt_fault_b;

    // Handlers apply their checks in order; a later mode write wins.
    always_comb
    begin
        st_next = st_reg;
        st_next.pend[csmc_pkg::CMD_LOCK_BIT]   = st_reg.pend[csmc_pkg::CMD_LOCK_BIT]
                                                 | word.lock_req;
        st_next.pend[csmc_pkg::CMD_UNLOCK_BIT] = st_reg.pend[csmc_pkg::CMD_UNLOCK_BIT]
                                                 | word.unlock_req;
        st_next.pend[csmc_pkg::CMD_CHARGE_BIT] = st_reg.pend[csmc_pkg::CMD_CHARGE_BIT]
                                                 | word.charge_req;
        st_next.pend[csmc_pkg::CMD_STOP_BIT]   = st_reg.pend[csmc_pkg::CMD_STOP_BIT]
                                                 | word.stop_req;

        case (st_reg.mode)
            csmc_pkg::MODE_STANDBY:
            begin
                if (word.charger_fault)
                begin
                    st_next.prev = st_next.mode;
                    st_next.mode = csmc_pkg::MODE_FAULT;
                end
                if (st_next.pend[csmc_pkg::CMD_UNLOCK_BIT])
                begin
                    st_next.lock = 1'b0;
                end
                if (word.is_battery && !st_reg.bus_err)
                begin
                    st_next.prev = st_next.mode;
                    st_next.mode = csmc_pkg::MODE_SWAP;
                    st_next.wake = 1'b0;
                end
                else
                begin
                    st_next.wake = 1'b1;
                end
                if (word.hw_failure)
                begin
                    st_next.mode = csmc_pkg::MODE_FAULT;
                end
            end

            csmc_pkg::MODE_SWAP:
            begin
                if (bfault)
                begin
                    st_next.mode = csmc_pkg::MODE_STANDBY;
                end
                if (st_next.pend[csmc_pkg::CMD_LOCK_BIT])
                begin
                    st_next.lock = 1'b1;
                    st_next.pend[csmc_pkg::CMD_LOCK_BIT] = 1'b0;
                end
                if (st_next.pend[csmc_pkg::CMD_UNLOCK_BIT])
                begin
                    st_next.lock = 1'b0;
                    st_next.pend[csmc_pkg::CMD_UNLOCK_BIT] = 1'b0;
                end
                if (st_next.lock && st_next.pend[csmc_pkg::CMD_CHARGE_BIT])
                begin
                    st_next.prev = st_next.mode;
                    st_next.mode = csmc_pkg::MODE_CHARGING;
                end
                if (word.hw_failure)
                begin
                    st_next.prev = st_next.mode;
                    st_next.mode = csmc_pkg::MODE_FAULT;
                end
                if (word.charger_fault)
                begin
                    st_next.prev = st_next.mode;
                    st_next.mode = csmc_pkg::MODE_FAULT;
                end
            end

            csmc_pkg::MODE_CHARGING:
            begin
                if (word.is_battery)
                begin
                    if (word.charge_level >= full_level
                        || st_next.pend[csmc_pkg::CMD_STOP_BIT])
                    begin
                        st_next.pend[csmc_pkg::CMD_STOP_BIT] = 1'b0;
                        st_next.batt_cmd = csmc_pkg::BATT_STOP;
                        st_next.chg_dis  = 1'b1;
                        st_next.chg_on   = 1'b0;
                        st_next.led      = csmc_pkg::LED_IDLE;
                    end
                    if (st_next.pend[csmc_pkg::CMD_UNLOCK_BIT] && !st_next.chg_on)
                    begin
                        st_next.led = csmc_pkg::LED_READY;
                        if (bfault)
                        begin
                            st_next.pend[csmc_pkg::CMD_UNLOCK_BIT] = 1'b0;
                            st_next.lock = 1'b0;
                            st_next.prev = st_next.mode;
                            st_next.mode = csmc_pkg::MODE_STANDBY;
                        end
                    end
                    if (st_next.pend[csmc_pkg::CMD_CHARGE_BIT])
                    begin
                        st_next.batt_cmd = csmc_pkg::BATT_CHARGE;
                        st_next.chg_dis  = 1'b0;
                        st_next.chg_on   = 1'b1;
                        st_next.pend[csmc_pkg::CMD_CHARGE_BIT] = 1'b0;
                    end
                end
                else
                begin
                    // battery pulled out mid-session
                    st_next.pend[csmc_pkg::CMD_UNLOCK_BIT] = 1'b0;
                    st_next.lock = 1'b0;
                    st_next.prev = st_next.mode;
                    st_next.mode = csmc_pkg::MODE_STANDBY;
                end
                if (word.hw_failure)
                begin
                    st_next.prev = st_next.mode;
                    st_next.mode = csmc_pkg::MODE_FAULT;
                end
                if (!st_next.pend[csmc_pkg::CMD_UNLOCK_BIT] && (bfault || word.charger_fault))
                begin
                    st_next.prev = st_next.mode;
                    st_next.mode = csmc_pkg::MODE_FAULT;
                end
            end

            csmc_pkg::MODE_FAULT:
            begin
                if (word.hw_failure)
                begin
                    st_next.batt_cmd = csmc_pkg::BATT_STOP;
                    st_next.chg_dis  = 1'b1;
                end
                else if (bfault || word.charger_fault)
                begin
                    case (st_reg.prev)
                        csmc_pkg::MODE_STANDBY:
                        begin
                            if (word.charger_fault)
                            begin
                                st_next.bus_err = 1'b1;
                            end
                            else
                            begin
                                st_next.mode = csmc_pkg::MODE_STANDBY;
                            end
                        end
                        csmc_pkg::MODE_SWAP:
                        begin
                            if (word.charger_fault)
                            begin
                                st_next.bus_err = 1'b1;
                            end
                        end
                        csmc_pkg::MODE_CHARGING:
                        begin
                            if (bfault)
                            begin
                                st_next.mode = csmc_pkg::MODE_THEFT;
                            end
                            else
                            begin
                                st_next.bus_err = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    st_next.mode = st_reg.prev;
                end
            end

            // theft holds
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode     <= csmc_pkg::MODE_STANDBY;
            st_reg.prev     <= csmc_pkg::MODE_STANDBY;
            st_reg.lock     <= 1'b0;
            st_reg.wake     <= 1'b0;
            st_reg.batt_cmd <= 8'd0;
            st_reg.chg_dis  <= 1'b0;
            st_reg.chg_on   <= 1'b0;
            st_reg.led      <= csmc_pkg::LED_NONE;
            st_reg.bus_err  <= 1'b0;
            st_reg.pend     <= 4'd0;
        end
        else if (adv)
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        result_next.mode            = csmc_pkg::mode_code(st_next.mode);
        result_next.prior_mode      = csmc_pkg::mode_code(st_next.prev);
        result_next.locked          = st_next.lock;
        result_next.wake_request    = st_next.wake;
        result_next.battery_command = st_next.batt_cmd;
        result_next.charger_disable = st_next.chg_dis;
        result_next.charging_on     = st_next.chg_on;
        result_next.led_code        = st_next.led;
        result_next.bus_error       = st_next.bus_err;
        result_next.unlock_waiting  = st_next.pend[csmc_pkg::CMD_UNLOCK_BIT];
    end

    assign state = st_reg;

endmodule

`default_nettype wire

FILE: rtl/core/charge_slot_mode_controller_unit.sv
// Charge slot mode controller: one input word per tick, one result word per tick.
// Every word passes through the input register, then the result register, on its way
// to the result; a new word is taken every cycle as long as the result side
// keeps up, the mode update itself being combinational flag logic. The
// threshold register is written over the cfg channel, which is always ready,
// and should only be written while no word is in flight.
// Depends on csmc_pkg, csmc_channels, csmc_in_reg, csmc_core and the defines header.
`default_nettype none
`include "charge_slot_mode_controller_unit_defines.svh"

module charge_slot_mode_controller_unit (
    input  wire logic      clk,
    input  wire logic      rst_n,
    csmc_item_if.sink      item,
    csmc_result_if.source  result,
    csmc_cfg_if.sink       cfg
);

    csmc_pkg::in_item_t    word;
    logic                  word_valid;
    logic                  adv;
    csmc_pkg::out_item_t   result_next;
    csmc_pkg::slot_state_t state;

    logic [7:0]            full_level_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    csmc_pkg::out_item_t   out_data_reg;

    // held word moves on when the result register is free or being emptied
    assign adv = word_valid && (!out_valid_reg || result.ready);

    csmc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .adv        (adv),
        .word       (word),
        .word_valid (word_valid)
    );

    csmc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .word        (word),
        .full_level  (full_level_reg),
        .result_next (result_next),
        .state       (state)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_level_reg <= csmc_pkg::FULL_LEVEL_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            full_level_reg <= cfg.data;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= result_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // bus error never clears once raised
    `CSMC_ASSERT_NEXT(a_bus_err_sticky, state.bus_err, state.bus_err)
    // theft is a dead end
    `CSMC_ASSERT_NEXT(a_theft_holds, state.mode == csmc_pkg::MODE_THEFT,
                      state.mode == csmc_pkg::MODE_THEFT)
    // slot state only moves when a word is consumed
    `CSMC_ASSERT_NEXT(a_state_moves_on_adv, !adv, $stable(state))
    // a consumed word always lands in a free or draining result register
    `CSMC_ASSERT_NOW(a_no_overwrite, adv, !out_valid_reg || result.ready)

endmodule

`default_nettype wire

FILE: bench/tb_charge_slot_mode_controller_unit.sv
`timescale 1ns / 1ps
// Testbench for charge_slot_mode_controller_unit: drives tick words, predicts each
// result word with a local model of the slot mode machine and checks it field by field.
// Depends on csmc_pkg, csmc_channels and the controller RTL.

module tb_charge_slot_mode_controller_unit;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 150;

    // local copy of the slot state, result encoding
    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] prior;
        logic       locked;
        logic       wake;
        logic [7:0] batt_cmd;
        logic       chg_dis;
        logic       chg_on;
        logic [1:0] led;
        logic       bus_err;
        logic [3:0] pend;
    } slot_model_t;

    logic clk;
    logic rst_n;

    csmc_item_if   item_ch ();
    csmc_result_if res_ch ();
    csmc_cfg_if    cfg_ch ();

    charge_slot_mode_controller_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    slot_model_t         slot;
    logic [7:0]          full_level;
    csmc_pkg::out_item_t due_words[$];
    csmc_pkg::out_item_t due_head;
    int                  n_err;
    int                  quiet;

    // receiver side
    logic [7:0]  rx_pattern;
    logic [2:0]  rx_phase;
    int          hold_asked;
    int          hold_taken;
    int          hold_left;

    always #2 clk = ~clk;

    function automatic slot_model_t advance_slot(slot_model_t s, csmc_pkg::in_item_t w,
                                                 logic [7:0] full);
        logic bf;
        logic cf;
        bf = w.batt_fault_a | w.batt_fault_b;
        cf = w.charger_fault;
        if (w.lock_req)
            s.pend[csmc_pkg::CMD_LOCK_BIT] = 1'b1;
        if (w.unlock_req)
            s.pend[csmc_pkg::CMD_UNLOCK_BIT] = 1'b1;
        if (w.charge_req)
            s.pend[csmc_pkg::CMD_CHARGE_BIT] = 1'b1;
        if (w.stop_req)
            s.pend[csmc_pkg::CMD_STOP_BIT] = 1'b1;
        case (s.mode)
            csmc_pkg::MODE_CODE_STANDBY:
            begin
                if (cf)
                begin
                    s.prior = s.mode;
                    s.mode  = csmc_pkg::MODE_CODE_FAULT;
                end
                if (s.pend[csmc_pkg::CMD_UNLOCK_BIT])
                    s.locked = 1'b0;
                if (w.is_battery && !s.bus_err)
                begin
                    s.prior = s.mode;
                    s.mode  = csmc_pkg::MODE_CODE_SWAP;
                    s.wake  = 1'b0;
                end
                else
                    s.wake = 1'b1;
                // no transition record here, the mode is simply overwritten
                if (w.hw_failure)
                    s.mode = csmc_pkg::MODE_CODE_FAULT;
            end
            csmc_pkg::MODE_CODE_SWAP:
            begin
                if (bf)
                    s.mode = csmc_pkg::MODE_CODE_STANDBY;
                if (s.pend[csmc_pkg::CMD_LOCK_BIT])
                begin
                    s.locked = 1'b1;
                    s.pend[csmc_pkg::CMD_LOCK_BIT] = 1'b0;
                end
                if (s.pend[csmc_pkg::CMD_UNLOCK_BIT])
                begin
                    s.locked = 1'b0;
                    s.pend[csmc_pkg::CMD_UNLOCK_BIT] = 1'b0;
                end
                if (s.locked && s.pend[csmc_pkg::CMD_CHARGE_BIT])
                begin
                    s.prior = s.mode;
                    s.mode  = csmc_pkg::MODE_CODE_CHARGING;
                end
                if (w.hw_failure)
                begin
                    s.prior = s.mode;
                    s.mode  = csmc_pkg::MODE_CODE_FAULT;
                end
                if (cf)
                begin
                    s.prior = s.mode;
                    s.mode  = csmc_pkg::MODE_CODE_FAULT;
                end
            end
            csmc_pkg::MODE_CODE_CHARGING:
            begin
                if (w.is_battery)
                begin
                    if (w.charge_level >= full || s.pend[csmc_pkg::CMD_STOP_BIT])
                    begin
                        s.pend[csmc_pkg::CMD_STOP_BIT] = 1'b0;
                        s.batt_cmd = csmc_pkg::BATT_STOP;
                        s.chg_dis  = 1'b1;
                        s.chg_on   = 1'b0;
                        s.led      = csmc_pkg::LED_IDLE;
                    end
                    if (s.pend[csmc_pkg::CMD_UNLOCK_BIT] && !s.chg_on)
                    begin
                        s.led = csmc_pkg::LED_READY;
                        if (bf)
                        begin
                            s.pend[csmc_pkg::CMD_UNLOCK_BIT] = 1'b0;
                            s.locked = 1'b0;
                            s.prior  = s.mode;
                            s.mode   = csmc_pkg::MODE_CODE_STANDBY;
                        end
                    end
                    if (s.pend[csmc_pkg::CMD_CHARGE_BIT])
                    begin
                        s.batt_cmd = csmc_pkg::BATT_CHARGE;
                        s.chg_dis  = 1'b0;
                        s.chg_on   = 1'b1;
                        s.pend[csmc_pkg::CMD_CHARGE_BIT] = 1'b0;
                    end
                end
                else
                begin
                    s.pend[csmc_pkg::CMD_UNLOCK_BIT] = 1'b0;
                    s.locked = 1'b0;
                    s.prior  = s.mode;
                    s.mode   = csmc_pkg::MODE_CODE_STANDBY;
                end
                if (w.hw_failure)
                begin
                    s.prior = s.mode;
                    s.mode  = csmc_pkg::MODE_CODE_FAULT;
                end
                if (!s.pend[csmc_pkg::CMD_UNLOCK_BIT] && (bf || cf))
                begin
                    s.prior = s.mode;
                    s.mode  = csmc_pkg::MODE_CODE_FAULT;
                end
            end
            csmc_pkg::MODE_CODE_FAULT:
            begin
                if (w.hw_failure)
                begin
                    s.batt_cmd = csmc_pkg::BATT_STOP;
                    s.chg_dis  = 1'b1;
                end
                else if (bf || cf)
                begin
                    if (s.prior == csmc_pkg::MODE_CODE_STANDBY)
                    begin
                        if (cf)
                            s.bus_err = 1'b1;
                        else
                            s.mode = csmc_pkg::MODE_CODE_STANDBY;
                    end
                    else if (s.prior == csmc_pkg::MODE_CODE_SWAP)
                    begin
                        if (cf)
                            s.bus_err = 1'b1;
                    end
                    else if (s.prior == csmc_pkg::MODE_CODE_CHARGING)
                    begin
                        if (bf)
                            s.mode = csmc_pkg::MODE_CODE_THEFT;
                        else
                            s.bus_err = 1'b1;
                    end
                end
                else
                    s.mode = s.prior;
            end
            default:
            begin
                // theft holds
            end
        endcase
        return s;
    endfunction

    function automatic csmc_pkg::in_item_t mk(logic batt, logic hw, logic fa, logic fb,
                                              logic cf, logic [7:0] level, logic lk,
                                              logic ul, logic ch, logic st);
        csmc_pkg::in_item_t w;
        w.is_battery    = batt;
        w.hw_failure    = hw;
        w.batt_fault_a  = fa;
        w.batt_fault_b  = fb;
        w.charger_fault = cf;
        w.charge_level  = level;
        w.lock_req      = lk;
        w.unlock_req    = ul;
        w.charge_req    = ch;
        w.stop_req      = st;
        return w;
    endfunction

    // mostly a plausible tick: battery in, faults rare, commands now and then
    function automatic csmc_pkg::in_item_t rand_item(bit noisy);
        csmc_pkg::in_item_t w;
        logic [31:0]        r;
        int                 lv;
        r = $urandom;
        if (noisy)
        begin
            w = r[$bits(csmc_pkg::in_item_t)-1:0];
            return w;
        end
        w.is_battery    = ($urandom_range(0, 7) != 0);
        w.hw_failure    = ($urandom_range(0, 15) == 0);
        w.batt_fault_a  = ($urandom_range(0, 11) == 0);
        w.batt_fault_b  = ($urandom_range(0, 11) == 0);
        w.charger_fault = ($urandom_range(0, 15) == 0);
        if (r[0])
            w.charge_level = r[15:8];
        else
        begin
            lv = int'(full_level) - 3;
            lv = lv + int'($urandom_range(0, 6));
            if (lv < 0)
                lv = 0;
            if (lv > 255)
                lv = 255;
            w.charge_level = lv[7:0];
        end
        w.lock_req   = ($urandom_range(0, 3) == 0);
        w.unlock_req = ($urandom_range(0, 3) == 0);
        w.charge_req = ($urandom_range(0, 3) == 0);
        w.stop_req   = ($urandom_range(0, 3) == 0);
        return w;
    endfunction

    // keeps clear of the states that never let go (theft, sticky bus error,
    // fault recorded over fault) so the run keeps exploring
    function automatic csmc_pkg::in_item_t pick_safe_item();
        csmc_pkg::in_item_t w;
        slot_model_t        nxt;
        int                 k;
        for (k = 0; k < 16; k++)
        begin
            w   = rand_item($urandom_range(0, 7) == 0);
            nxt = advance_slot(slot, w, full_level);
            if (!nxt.bus_err && nxt.mode != csmc_pkg::MODE_CODE_THEFT &&
                !(nxt.mode == csmc_pkg::MODE_CODE_FAULT &&
                  nxt.prior == csmc_pkg::MODE_CODE_FAULT))
                return w;
        end
        return '0;
    endfunction

    task automatic send_word(csmc_pkg::in_item_t w);
        csmc_pkg::out_item_t r;
        item_ch.data  <= w;
        item_ch.valid <= 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        slot = advance_slot(slot, w, full_level);
        r.mode            = slot.mode;
        r.prior_mode      = slot.prior;
        r.locked          = slot.locked;
        r.wake_request    = slot.wake;
        r.battery_command = slot.batt_cmd;
        r.charger_disable = slot.chg_dis;
        r.charging_on     = slot.chg_on;
        r.led_code        = slot.led;
        r.bus_error       = slot.bus_err;
        r.unlock_waiting  = slot.pend[csmc_pkg::CMD_UNLOCK_BIT];
        due_words.push_back(r);
    endtask

    task automatic wait_drain();
        item_ch.valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_full_level(logic [7:0] v);
        wait_drain();
        cfg_ch.data  <= v;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        full_level = v;
    endtask

    task automatic run_items(int count, bit filtered, bit gaps_on);
        int                 left;
        int                 burst;
        int                 gap;
        csmc_pkg::in_item_t w;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                w = filtered ? pick_safe_item() : rand_item(1'b1);
                send_word(w);
            end
            left -= burst;
            gap = ($urandom_range(0, 3) == 0 || !gaps_on) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_err++;
        end
    endtask

    task automatic test_directed();
        rx_pattern = 8'hFF;
        send_word(mk(0, 0, 0, 0, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(0, 0, 0, 0, 0, 8'd255, 0, 1, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd0,   1, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd0,   0, 0, 1, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd0,   1, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd50,  0, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd100, 0, 0, 0, 0));
        // stop and charge in the same tick: charge is applied last
        send_word(mk(1, 0, 0, 0, 0, 8'd0,   0, 0, 1, 1));
        send_word(mk(1, 0, 0, 0, 0, 8'd10,  0, 1, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd10,  0, 0, 0, 1));
        // unlock with bus trouble: back to standby, then into fault at once
        send_word(mk(1, 0, 1, 0, 0, 8'd10,  0, 0, 0, 0));
        send_word(mk(1, 0, 0, 1, 0, 8'd10,  0, 0, 0, 0));
        send_word(mk(0, 1, 0, 0, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(0, 1, 0, 0, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(0, 0, 0, 0, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd200, 0, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 1, 8'd0,   0, 0, 0, 0));
        send_word(mk(1, 0, 1, 1, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(1, 1, 0, 0, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(1, 0, 0, 1, 0, 8'd0,   0, 0, 0, 0));
        send_word(mk(0, 0, 0, 0, 1, 8'd0,   0, 0, 0, 0));
        send_word(mk(0, 0, 0, 0, 0, 8'd0,   0, 0, 0, 0));
        wait_drain();
    endtask

    task automatic test_threshold_extremes();
        write_full_level(8'd0);
        rx_pattern = 8'($urandom | 32'h1);
        run_items(100, 1'b1, 1'b1);
        write_full_level(8'd255);
        rx_pattern = 8'hFF;
        run_items(100, 1'b1, 1'b1);
        write_full_level(8'($urandom_range(1, 254)));
        rx_pattern = 8'b1011_0111;
        run_items(100, 1'b1, 1'b1);
        write_full_level(csmc_pkg::FULL_LEVEL_RST);
    endtask

    task automatic test_random_traffic();
        rx_pattern = 8'hFF;
        run_items(250, 1'b1, 1'b0);
        rx_pattern = 8'($urandom | 32'h1);
        run_items(250, 1'b1, 1'b1);
        rx_pattern = 8'h55;
        run_items(250, 1'b1, 1'b1);
        write_full_level(8'($urandom));
        rx_pattern = 8'($urandom | 32'h1);
        run_items(250, 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        rx_pattern = 8'hFF;
        hold_asked++;
        run_items(200, 1'b1, 1'b0);
        wait_drain();
        rx_pattern = 8'b1110_1101;
        run_items(50, 1'b1, 1'b1);
    endtask

    // steer into charging, set the bus error from there, then fall into theft
    task automatic test_theft_hold();
        int guard;
        guard = 0;
        rx_pattern = 8'hFF;
        while (!(slot.mode == csmc_pkg::MODE_CODE_CHARGING &&
                 !slot.pend[csmc_pkg::CMD_UNLOCK_BIT]) && guard < 40)
        begin
            case (slot.mode)
                csmc_pkg::MODE_CODE_SWAP:
                    send_word(mk(1, 0, 0, 0, 0, 8'd0, 1, 0, 1, 0));
                csmc_pkg::MODE_CODE_CHARGING:
                    send_word(mk(0, 0, 0, 0, 0, 8'd0, 0, 0, 0, 0));
                default:
                    send_word(mk(1, 0, 0, 0, 0, 8'd0, 0, 0, 0, 0));
            endcase
            guard++;
        end
        send_word(mk(1, 0, 0, 0, 1, 8'd0, 0, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 1, 8'd0, 0, 0, 0, 0));
        send_word(mk(1, 0, 0, 0, 0, 8'd0, 0, 0, 0, 0));
        send_word(mk(1, 0, 1, 0, 0, 8'd0, 0, 0, 0, 0));
        send_word(mk(1, 0, 0, 1, 0, 8'd0, 0, 0, 0, 0));
        rx_pattern = 8'($urandom | 32'h1);
        run_items(40, 1'b0, 1'b1);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        rx_pattern    = 8'hFF;
        rx_phase      = '0;
        hold_asked    = 0;
        hold_taken    = 0;
        hold_left     = 0;
        n_err         = 0;
        quiet         = 0;
        full_level    = csmc_pkg::FULL_LEVEL_RST;
        slot          = '0;
        slot.mode     = csmc_pkg::MODE_CODE_STANDBY;
        slot.prior    = csmc_pkg::MODE_CODE_STANDBY;
        slot.led      = csmc_pkg::LED_NONE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_extremes();
        test_random_traffic();
        test_backpressure();
        test_theft_hold();

        wait_drain();
        repeat (8) @(posedge clk);
        if (n_err == 0)
            $display("[charge_slot_mode_controller_unit] OK");
        else
            $display("[charge_slot_mode_controller_unit] ERROR");
        $finish;
    end

    // receiver: stall pattern, or a long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken   <= hold_asked;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            rx_phase     <= rx_phase + 3'd1;
            res_ch.ready <= rx_pattern[rx_phase];
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (due_words.size() == 0)
            begin
                $error("result word with nothing expected");
                n_err++;
            end
            else
            begin
                due_head = due_words.pop_front();
                check_field("mode", due_head.mode, res_ch.data.mode);
                check_field("prior_mode", due_head.prior_mode, res_ch.data.prior_mode);
                check_field("locked", due_head.locked, res_ch.data.locked);
                check_field("wake_request", due_head.wake_request, res_ch.data.wake_request);
                check_field("battery_command", due_head.battery_command,
                            res_ch.data.battery_command);
                check_field("charger_disable", due_head.charger_disable,
                            res_ch.data.charger_disable);
                check_field("charging_on", due_head.charging_on, res_ch.data.charging_on);
                check_field("led_code", due_head.led_code, res_ch.data.led_code);
                check_field("bus_error", due_head.bus_error, res_ch.data.bus_error);
                check_field("unlock_waiting", due_head.unlock_waiting,
                            res_ch.data.unlock_waiting);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[charge_slot_mode_controller_unit] ERROR");
            $finish;
        end
    end

endmodule
